// ----- rtl/tetrahedron_barycentric_weights_top_defines.svh -----
// Assertion macros used by the top-level RTL of the barycentric weight block.
`ifndef TETRAHEDRON_BARYCENTRIC_WEIGHTS_TOP_DEFINES_SVH
`define TETRAHEDRON_BARYCENTRIC_WEIGHTS_TOP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define TBW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tbw assertion failed");
// Next-cycle implication.
`define TBW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tbw assertion failed");
`else
`define TBW_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TBW_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/tbw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tbw_pkg;

    localparam int VERTEX_DEPTH  = 1024;
    localparam int ELEMENT_DEPTH = 1024;
    localparam int COORD_WIDTH   = 16;
    localparam int FRACTION_BITS = 16;

    localparam int REQ_W    = 2;
    localparam int VIDX_W   = 10;
    localparam int EIDX_W   = 10;
    localparam int CORNER_W = 2;
    localparam int WEIGHT_W = 24;
    localparam int NUM_CORNERS = 4;
    localparam int LAST_CORNER = NUM_CORNERS - 1;
    localparam int NUM_DET     = NUM_CORNERS + 1;

    localparam int VADDR_W = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int EADDR_W = (ELEMENT_DEPTH > 1) ? $clog2(ELEMENT_DEPTH) : 1;
    localparam int VERT_W  = 3 * COORD_WIDTH;

    // Determinant datapath widths, exact for any coordinate width.
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int DOT_W   = DIFF_W + CROSS_W;
    localparam int DET_W   = DOT_W + 2;
    localparam int DIV_W   = DET_W +
        ((FRACTION_BITS > WEIGHT_W) ? FRACTION_BITS : WEIGHT_W) + 1;

    localparam logic [WEIGHT_W-1:0] WPOS_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic [WEIGHT_W-1:0] WNEG_MAG = {1'b1, {(WEIGHT_W-1){1'b0}}};

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Stream packing.
    localparam int OFF_EIDX   = VIDX_W;
    localparam int OFF_CORNER = OFF_EIDX + EIDX_W;
    localparam int OFF_X      = OFF_CORNER + CORNER_W;
    localparam int OFF_Y      = OFF_X + COORD_WIDTH;
    localparam int OFF_Z      = OFF_Y + COORD_WIDTH;
    localparam int S_TDATA_W  = ((OFF_Z + COORD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((NUM_CORNERS * WEIGHT_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_VERTEX = 2'd0,
        REQ_CORNER = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_UNUSED = 2'd3
    } req_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef coord_t [2:0] point_t;
    typedef logic signed [DET_W-1:0] det_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;

    typedef struct packed {
        logic                         valid;
        logic                         oob;
        point_t [NUM_CORNERS-1:0]     corner;
        point_t                       pt;
    } tet_job_t;

    typedef struct packed {
        logic                 valid;
        logic                 oob;
        det_t [NUM_DET-1:0]   det;
    } det_set_t;

    typedef struct packed {
        weight_t [NUM_CORNERS-1:0] weight;
        logic                      in_tet;
        logic                      degen;
        logic                      sat;
    } result_t;

    function automatic logic [DET_W-1:0] det_mag(input det_t d);
        det_mag = d[DET_W-1] ? (~d + 1'b1) : d;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/tetrahedron_barycentric_weights_top.sv -----
// Barycentric weights of a point in a tetrahedron of a stored mesh.
// Input stream (s_*): s_tuser selects the request: write a vertex, write one
// corner of a tetrahedron, or query a point against a stored tetrahedron.
// Writes produce no output word; each query produces exactly one word on
// the output stream (m_*): four signed weights with 16 fraction bits in
// m_tdata and the inside, degenerate and saturated flags in m_tuser.
// A write word is done once accepted. A query word holds the input for
// the four corner reads from the vertex memory; the next word is accepted
// in the last of them. The determinants and the divider are fully
// pipelined behind the fetch stage and drain into a 16-word output FIFO.
// When the receiver stalls, results collect in the FIFO; s_tready drops
// once 16 queries are outstanding, so no result is ever dropped.
// Reset clears the control state only; the mesh memories are not cleared
// and must be written before a query refers to them.
`timescale 1ns / 1ps
`default_nettype none
`include "tetrahedron_barycentric_weights_top_defines.svh"
module tetrahedron_barycentric_weights_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // vertex_index, element_index, corner, coord_x, coord_y, coord_z, zero fill
    input  logic [tbw_pkg::S_TDATA_W-1:0]     s_tdata,
    // req_type
    input  logic [tbw_pkg::REQ_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // weight_a, weight_b, weight_c, weight_d
    output logic [tbw_pkg::M_TDATA_W-1:0]     m_tdata,
    // inside_res, degenerate, saturated
    output logic [tbw_pkg::M_TUSER_W-1:0]     m_tuser
);
    tbw_pkg::point_t   in_pt;
    tbw_pkg::tet_job_t job;
    tbw_pkg::det_set_t dset;
    tbw_pkg::result_t  res, head;
    logic res_valid, credit_ok, q_acc, pop;

    tbw_pkg::result_t                 fifo_mem_reg [tbw_pkg::FIFO_DEPTH];
    logic [tbw_pkg::FIFO_AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [tbw_pkg::CNT_W-1:0]        fill_reg, fill_next, out_cnt_reg, out_cnt_next;

    assign in_pt[0] = s_tdata[tbw_pkg::OFF_X +: tbw_pkg::COORD_WIDTH];
    assign in_pt[1] = s_tdata[tbw_pkg::OFF_Y +: tbw_pkg::COORD_WIDTH];
    assign in_pt[2] = s_tdata[tbw_pkg::OFF_Z +: tbw_pkg::COORD_WIDTH];

    // Outstanding queries, counted from acceptance until their word is taken.
    assign credit_ok = int'(out_cnt_reg) < tbw_pkg::FIFO_DEPTH;
    assign q_acc     = s_tvalid && s_tready && (s_tuser == tbw_pkg::REQ_QUERY);
    assign pop       = m_tvalid && m_tready;

    tbw_fetch u_fetch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .credit_ok (credit_ok),
        .in_req    (s_tuser),
        .in_vidx   (s_tdata[0 +: tbw_pkg::VIDX_W]),
        .in_eidx   (s_tdata[tbw_pkg::OFF_EIDX +: tbw_pkg::EIDX_W]),
        .in_corner (s_tdata[tbw_pkg::OFF_CORNER +: tbw_pkg::CORNER_W]),
        .in_pt     (in_pt),
        .job       (job)
    );

    tbw_det u_det (
        .aclk    (aclk),
        .aresetn (aresetn),
        .job     (job),
        .dset    (dset)
    );

    tbw_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dset      (dset),
        .res_valid (res_valid),
        .res       (res)
    );

    assign fill_next    = fill_reg + tbw_pkg::CNT_W'(res_valid) - tbw_pkg::CNT_W'(pop);
    assign out_cnt_next = out_cnt_reg + tbw_pkg::CNT_W'(q_acc) - tbw_pkg::CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            out_cnt_reg <= '0;
        end else begin
            if (res_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg    <= fill_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            fifo_mem_reg[wr_ptr_reg] <= res;
        end
    end

    assign head     = fifo_mem_reg[rd_ptr_reg];
    assign m_tvalid = fill_reg != '0;
    assign m_tdata  = tbw_pkg::M_TDATA_W'(head.weight);
    assign m_tuser  = {head.sat, head.degen, head.in_tet};

    `TBW_ASSERT_IMP(a_fifo_no_overflow, aclk, aresetn, res_valid, pop || (int'(fill_reg) < tbw_pkg::FIFO_DEPTH))
    `TBW_ASSERT_IMP(a_fill_le_credit, aclk, aresetn, 1'b1, fill_reg <= out_cnt_reg)
    `TBW_ASSERT_NXT(a_query_blocks_next, aclk, aresetn, q_acc, !s_tready)
endmodule
`default_nettype wire

// ----- rtl/tbw_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tbw_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read-first: a read and a write to one address in a cycle return old data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

// ----- rtl/tbw_fetch.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tbw_fetch (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            credit_ok,
    input  logic [tbw_pkg::REQ_W-1:0]       in_req,
    input  logic [tbw_pkg::VIDX_W-1:0]      in_vidx,
    input  logic [tbw_pkg::EIDX_W-1:0]      in_eidx,
    input  logic [tbw_pkg::CORNER_W-1:0]    in_corner,
    input  tbw_pkg::point_t                 in_pt,
    output tbw_pkg::tet_job_t               job
);
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } fetch_state_t;

    fetch_state_t state_reg, state_next;
    logic [tbw_pkg::CORNER_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic accept, is_query, last_rd, v_oob, e_oob, cur_oob;
    logic [tbw_pkg::VIDX_W-1:0] elem_vidx [tbw_pkg::NUM_CORNERS];
    logic [tbw_pkg::VIDX_W-1:0] cur_vidx;
    logic [tbw_pkg::VERT_W-1:0] vert_rdata;

    logic                         cap_vld_reg, cap_oob_reg;
    logic [tbw_pkg::CORNER_W-1:0] cap_cnt_reg;
    tbw_pkg::point_t              corner_reg [tbw_pkg::LAST_CORNER];
    tbw_pkg::point_t              pt_reg, pt_hold_reg;
    logic                         eoob_reg, eoob_hold_reg;

    assign last_rd  = (state_reg == ST_READ) &&
                      (rd_cnt_reg == tbw_pkg::CORNER_W'(tbw_pkg::LAST_CORNER));
    // The next word is taken while the last corner read is issued.
    assign in_ready = ((state_reg == ST_IDLE) || last_rd) && credit_ok;
    assign accept   = in_valid && in_ready;
    assign is_query = accept && (in_req == tbw_pkg::REQ_QUERY);
    assign v_oob    = int'(in_vidx) >= tbw_pkg::VERTEX_DEPTH;
    assign e_oob    = int'(in_eidx) >= tbw_pkg::ELEMENT_DEPTH;
    assign cur_vidx = elem_vidx[rd_cnt_reg];
    assign cur_oob  = int'(cur_vidx) >= tbw_pkg::VERTEX_DEPTH;

    always_comb begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (is_query) begin
                    state_next  = ST_READ;
                    rd_cnt_next = '0;
                end
            end
            ST_READ: begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (last_rd) begin
                    state_next  = is_query ? ST_READ : ST_IDLE;
                    rd_cnt_next = '0;
                end
            end
            default: begin
                state_next  = ST_IDLE;
                rd_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_cnt_reg  <= '0;
            cap_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            cap_vld_reg <= (state_reg == ST_READ);
        end
    end

    always_ff @(posedge aclk) begin
        cap_cnt_reg <= rd_cnt_reg;
        cap_oob_reg <= cur_oob;
        if (is_query) begin
            pt_reg   <= in_pt;
            eoob_reg <= e_oob;
        end
        if (last_rd) begin
            pt_hold_reg   <= pt_reg;
            eoob_hold_reg <= eoob_reg;
        end
        if (cap_vld_reg &&
            (cap_cnt_reg != tbw_pkg::CORNER_W'(tbw_pkg::LAST_CORNER))) begin
            corner_reg[cap_cnt_reg] <= cap_oob_reg ? '0 : vert_rdata;
        end
    end

    tbw_ram #(
        .WIDTH (tbw_pkg::VERT_W),
        .DEPTH (tbw_pkg::VERTEX_DEPTH)
    ) u_vertex_ram (
        .aclk    (aclk),
        .wr_en   (accept && (in_req == tbw_pkg::REQ_VERTEX) && !v_oob),
        .wr_addr (tbw_pkg::VADDR_W'(in_vidx)),
        .wr_data (in_pt),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (tbw_pkg::VADDR_W'(cur_vidx)),
        .rd_data (vert_rdata)
    );

    // One narrow memory per corner, so a corner write needs no read-modify-write.
    for (genvar c = 0; c < tbw_pkg::NUM_CORNERS; c++) begin : g_elem
        tbw_ram #(
            .WIDTH (tbw_pkg::VIDX_W),
            .DEPTH (tbw_pkg::ELEMENT_DEPTH)
        ) u_elem_ram (
            .aclk    (aclk),
            .wr_en   (accept && (in_req == tbw_pkg::REQ_CORNER) &&
                      (in_corner == tbw_pkg::CORNER_W'(c)) && !e_oob),
            .wr_addr (tbw_pkg::EADDR_W'(in_eidx)),
            .wr_data (in_vidx),
            .rd_en   (is_query),
            .rd_addr (tbw_pkg::EADDR_W'(in_eidx)),
            .rd_data (elem_vidx[c])
        );
    end

    always_comb begin
        job.valid     = cap_vld_reg &&
                        (cap_cnt_reg == tbw_pkg::CORNER_W'(tbw_pkg::LAST_CORNER));
        job.oob       = eoob_hold_reg;
        job.pt        = pt_hold_reg;
        job.corner[0] = corner_reg[0];
        job.corner[1] = corner_reg[1];
        job.corner[2] = corner_reg[2];
        job.corner[3] = cap_oob_reg ? '0 : vert_rdata;
    end
endmodule
`default_nettype wire

// ----- rtl/tbw_det.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tbw_det (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tbw_pkg::tet_job_t    job,
    output tbw_pkg::det_set_t    dset
);
    localparam int ND = tbw_pkg::NUM_DET;

    tbw_pkg::point_t pts [ND][tbw_pkg::NUM_CORNERS];
    logic signed [tbw_pkg::DIFF_W-1:0]  u_next [ND][3], v_next [ND][3], w_next [ND][3];
    logic signed [tbw_pkg::DIFF_W-1:0]  u1_reg [ND][3], v1_reg [ND][3], w1_reg [ND][3];
    logic signed [tbw_pkg::DIFF_W-1:0]  u2_reg [ND][3], u3_reg [ND][3];
    logic signed [tbw_pkg::PROD_W-1:0]  m_reg  [ND][6];
    logic signed [tbw_pkg::CROSS_W-1:0] cr_reg [ND][3];
    logic signed [tbw_pkg::DOT_W-1:0]   dp_reg [ND][3];
    tbw_pkg::det_t                      det_reg [ND];
    logic [4:0] vld_reg, oob_reg;

    // Set 0 is the tetrahedron itself; set i+1 has the point in place of corner i.
    always_comb begin
        for (int s = 0; s < ND; s++) begin
            for (int j = 0; j < tbw_pkg::NUM_CORNERS; j++) begin
                pts[s][j] = (s != 0 && j == s - 1) ? job.pt : job.corner[j];
            end
            for (int k = 0; k < 3; k++) begin
                u_next[s][k] = tbw_pkg::DIFF_W'($signed(pts[s][0][k])) -
                               tbw_pkg::DIFF_W'($signed(pts[s][3][k]));
                v_next[s][k] = tbw_pkg::DIFF_W'($signed(pts[s][1][k])) -
                               tbw_pkg::DIFF_W'($signed(pts[s][3][k]));
                w_next[s][k] = tbw_pkg::DIFF_W'($signed(pts[s][2][k])) -
                               tbw_pkg::DIFF_W'($signed(pts[s][3][k]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], job.valid};
        end
    end

    always_ff @(posedge aclk) begin
        oob_reg <= {oob_reg[3:0], job.oob};
        for (int s = 0; s < ND; s++) begin
            u1_reg[s] <= u_next[s];
            v1_reg[s] <= v_next[s];
            w1_reg[s] <= w_next[s];
            // Cross product terms of (b-d) x (c-d).
            m_reg[s][0] <= v1_reg[s][1] * w1_reg[s][2];
            m_reg[s][1] <= v1_reg[s][2] * w1_reg[s][1];
            m_reg[s][2] <= v1_reg[s][2] * w1_reg[s][0];
            m_reg[s][3] <= v1_reg[s][0] * w1_reg[s][2];
            m_reg[s][4] <= v1_reg[s][0] * w1_reg[s][1];
            m_reg[s][5] <= v1_reg[s][1] * w1_reg[s][0];
            u2_reg[s]   <= u1_reg[s];
            for (int k = 0; k < 3; k++) begin
                cr_reg[s][k] <= tbw_pkg::CROSS_W'(m_reg[s][2*k]) -
                                tbw_pkg::CROSS_W'(m_reg[s][2*k+1]);
                dp_reg[s][k] <= u3_reg[s][k] * cr_reg[s][k];
            end
            u3_reg[s]  <= u2_reg[s];
            det_reg[s] <= tbw_pkg::DET_W'(dp_reg[s][0]) + tbw_pkg::DET_W'(dp_reg[s][1]) +
                          tbw_pkg::DET_W'(dp_reg[s][2]);
        end
    end

    always_comb begin
        dset.valid = vld_reg[4];
        dset.oob   = oob_reg[4];
        for (int s = 0; s < ND; s++) begin
            dset.det[s] = det_reg[s];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/tbw_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tbw_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tbw_pkg::det_set_t    dset,
    output logic                 res_valid,
    output tbw_pkg::result_t     res
);
    localparam int NC = tbw_pkg::NUM_CORNERS;
    localparam int QW = tbw_pkg::WEIGHT_W;

    logic [tbw_pkg::DET_W-1:0] ud, un [NC];
    logic [tbw_pkg::DIV_W-1:0] num [NC];
    logic [NC-1:0] neg_n, ovf_n, same_n;
    logic degen_n, inside_n;

    logic [tbw_pkg::DIV_W-1:0] rem_reg [QW+1][NC];
    logic [QW-1:0]             quo_reg [QW+1][NC];
    logic [tbw_pkg::DET_W-1:0] den_reg [QW+1];
    logic [NC-1:0]             neg_reg [QW+1], ovf_reg [QW+1];
    logic [QW:0]               degen_reg, inside_reg, vld_reg;

    logic [QW-1:0]     q_fin [NC];
    logic [NC-1:0]     sat_fin;
    tbw_pkg::result_t  res_next, res_reg;
    logic              res_vld_reg;

    always_comb begin
        ud       = tbw_pkg::det_mag(dset.det[0]);
        degen_n  = dset.oob || (dset.det[0] == '0);
        for (int i = 0; i < NC; i++) begin
            un[i]     = tbw_pkg::det_mag(dset.det[i+1]);
            neg_n[i]  = dset.det[i+1][tbw_pkg::DET_W-1] ^ dset.det[0][tbw_pkg::DET_W-1];
            same_n[i] = (dset.det[i+1] == '0) || !neg_n[i];
            num[i]    = tbw_pkg::DIV_W'(un[i]) << tbw_pkg::FRACTION_BITS;
            // A quotient of 2^WEIGHT_W or more saturates in either sign.
            ovf_n[i]  = num[i] >= (tbw_pkg::DIV_W'(ud) << QW);
        end
        inside_n = !degen_n && (&same_n);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end else begin
            vld_reg     <= {vld_reg[QW-1:0], dset.valid};
            res_vld_reg <= vld_reg[QW];
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    always_ff @(posedge aclk) begin
        den_reg[0]    <= ud;
        neg_reg[0]    <= neg_n;
        ovf_reg[0]    <= ovf_n;
        degen_reg[0]  <= degen_n;
        inside_reg[0] <= inside_n;
        for (int i = 0; i < NC; i++) begin
            rem_reg[0][i] <= num[i];
            quo_reg[0][i] <= '0;
        end
        for (int s = 0; s < QW; s++) begin
            den_reg[s+1]    <= den_reg[s];
            neg_reg[s+1]    <= neg_reg[s];
            ovf_reg[s+1]    <= ovf_reg[s];
            degen_reg[s+1]  <= degen_reg[s];
            inside_reg[s+1] <= inside_reg[s];
            for (int i = 0; i < NC; i++) begin
                if (rem_reg[s][i] >= (tbw_pkg::DIV_W'(den_reg[s]) << (QW - 1 - s))) begin
                    rem_reg[s+1][i] <= rem_reg[s][i] -
                                       (tbw_pkg::DIV_W'(den_reg[s]) << (QW - 1 - s));
                    quo_reg[s+1][i] <= {quo_reg[s][i][QW-2:0], 1'b1};
                end else begin
                    rem_reg[s+1][i] <= rem_reg[s][i];
                    quo_reg[s+1][i] <= {quo_reg[s][i][QW-2:0], 1'b0};
                end
            end
        end
        res_reg <= res_next;
    end

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            if (neg_reg[QW][i]) begin
                sat_fin[i] = ovf_reg[QW][i] ||
                             (quo_reg[QW][i][QW-1] && (|quo_reg[QW][i][QW-2:0]));
                q_fin[i]   = sat_fin[i] ? tbw_pkg::WNEG_MAG : quo_reg[QW][i];
                q_fin[i]   = ~q_fin[i] + 1'b1;
            end else begin
                sat_fin[i] = ovf_reg[QW][i] || quo_reg[QW][i][QW-1];
                q_fin[i]   = sat_fin[i] ? tbw_pkg::WPOS_MAX : quo_reg[QW][i];
            end
        end
        res_next.in_tet = inside_reg[QW];
        res_next.degen  = degen_reg[QW];
        res_next.sat    = !degen_reg[QW] && (|sat_fin);
        for (int i = 0; i < NC; i++) begin
            res_next.weight[i] = degen_reg[QW] ? '0 : q_fin[i];
        end
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;
endmodule
`default_nettype wire

// ----- test/tbw_checker.sv -----
`timescale 1ns / 1ps
module tbw_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [tbw_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [tbw_pkg::REQ_W-1:0]     s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [tbw_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [tbw_pkg::M_TUSER_W-1:0] m_tuser,
    output int                            fail_count,
    output int                            pending
);
    import tbw_pkg::*;

    typedef struct {
        weight_t w[4];
        logic    in_tet;
        logic    degen;
        logic    sat;
    } answer_t;

    typedef longint tet_pts_t[4][3];

    coord_t            mesh_pos[VERTEX_DEPTH][3];
    logic [VIDX_W-1:0] tet_corner[ELEMENT_DEPTH][4];
    answer_t           answers_due[$];

    initial begin
        fail_count = 0;
        for (int i = 0; i < VERTEX_DEPTH; i++)
            for (int k = 0; k < 3; k++) mesh_pos[i][k] = '0;
        for (int i = 0; i < ELEMENT_DEPTH; i++)
            for (int k = 0; k < 4; k++) tet_corner[i][k] = '0;
    end

    assign pending = answers_due.size();

    // (a-d) . ((b-d) x (c-d))
    function automatic longint orient_det(input tet_pts_t p);
        longint u[3], v[3], w[3], cr[3];
        for (int k = 0; k < 3; k++) begin
            u[k] = p[0][k] - p[3][k];
            v[k] = p[1][k] - p[3][k];
            w[k] = p[2][k] - p[3][k];
        end
        cr[0] = v[1] * w[2] - v[2] * w[1];
        cr[1] = v[2] * w[0] - v[0] * w[2];
        cr[2] = v[0] * w[1] - v[1] * w[0];
        return u[0] * cr[0] + u[1] * cr[1] + u[2] * cr[2];
    endfunction

    function automatic weight_t fixed_ratio(input longint n, input longint d, inout logic sat);
        logic [63:0] un, ud, q, r;
        logic        neg;
        un  = (n < 0) ? 64'(-n) : 64'(n);
        ud  = (d < 0) ? 64'(-d) : 64'(d);
        neg = (n < 0) != (d < 0);
        q   = un / ud;
        r   = un % ud;
        // The integer part is capped early so the shifts cannot overflow.
        if (q > (64'd1 << 24)) q = 64'd1 << 24;
        for (int k = 0; k < FRACTION_BITS; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ud) begin
                r = r - ud;
                q[0] = 1'b1;
            end
        end
        if (neg) begin
            if (q > 64'd8388608) begin
                q = 64'd8388608;
                sat = 1'b1;
            end
            q = -q;
        end else if (q > 64'd8388607) begin
            q = 64'd8388607;
            sat = 1'b1;
        end
        return q[WEIGHT_W-1:0];
    endfunction

    function automatic answer_t barycentric(input logic [EIDX_W-1:0] e, input longint pt[3]);
        answer_t  a;
        tet_pts_t c, b;
        longint   d0, di;
        a.in_tet = 1'b0;
        a.degen  = 1'b0;
        a.sat    = 1'b0;
        for (int i = 0; i < 4; i++) a.w[i] = '0;
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++) c[i][k] = mesh_pos[tet_corner[e][i]][k];
        d0 = orient_det(c);
        if (d0 == 0) begin
            a.degen = 1'b1;
            return a;
        end
        a.in_tet = 1'b1;
        for (int i = 0; i < 4; i++) begin
            b = c;
            for (int k = 0; k < 3; k++) b[i][k] = pt[k];
            di = orient_det(b);
            if (di != 0 && ((di < 0) != (d0 < 0))) a.in_tet = 1'b0;
            a.w[i] = fixed_ratio(di, d0, a.sat);
        end
        return a;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        logic [VIDX_W-1:0]   vi;
        logic [EIDX_W-1:0]   ei;
        logic [CORNER_W-1:0] cn;
        longint              pt[3];
        answer_t             got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                vi = s_tdata[VIDX_W-1:0];
                ei = s_tdata[OFF_EIDX +: EIDX_W];
                cn = s_tdata[OFF_CORNER +: CORNER_W];
                pt[0] = coord_t'(s_tdata[OFF_X +: COORD_WIDTH]);
                pt[1] = coord_t'(s_tdata[OFF_Y +: COORD_WIDTH]);
                pt[2] = coord_t'(s_tdata[OFF_Z +: COORD_WIDTH]);
                case (s_tuser)
                    REQ_VERTEX: begin
                        for (int k = 0; k < 3; k++) mesh_pos[vi][k] = coord_t'(pt[k]);
                    end
                    REQ_CORNER: begin
                        tet_corner[ei][cn] = vi;
                    end
                    REQ_QUERY: begin
                        answers_due.push_back(barycentric(ei, pt));
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                for (int i = 0; i < 4; i++) got.w[i] = m_tdata[i*WEIGHT_W +: WEIGHT_W];
                got.in_tet = m_tuser[0];
                got.degen  = m_tuser[1];
                got.sat    = m_tuser[2];
                if (answers_due.size() == 0) begin
                    report("unexpected result word", 1, 0);
                end else begin
                    want = answers_due.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (got.w[i] !== want.w[i])
                            report($sformatf("weight %0d", i), got.w[i], want.w[i]);
                    if (got.in_tet !== want.in_tet) report("inside", got.in_tet, want.in_tet);
                    if (got.degen !== want.degen) report("degenerate", got.degen, want.degen);
                    if (got.sat !== want.sat) report("saturated", got.sat, want.sat);
                end
            end
        end
    end
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import tbw_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [REQ_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    int                   fail_count;
    int                   pending;

    int  cycles;
    int  words_sent;
    bit  no_idle;
    int  out_stall;
    int  built_tets[$];

    tetrahedron_barycentric_weights_top uut (.*);

    tbw_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        cycles   = 0;
        no_idle  = 1'b0;
        out_stall = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tetrahedron_barycentric_weights_top regression: fail");
            $finish;
        end
    end

    // Receiver: holds ready low for a drawn number of cycles before each word.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                out_stall = no_idle ? 0 : $urandom_range(0, 5);
                m_tready <= (out_stall == 0);
            end else if (out_stall > 0) begin
                out_stall--;
                m_tready <= (out_stall == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send(input logic [REQ_W-1:0] req, input logic [VIDX_W-1:0] vi,
                        input logic [EIDX_W-1:0] ei, input logic [CORNER_W-1:0] cn,
                        input coord_t x, input coord_t y, input coord_t z);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, z, y, x, cn, ei, vi};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (req != REQ_UNUSED) words_sent++;
    endtask

    task automatic put_vertex(input int vi, input coord_t x, input coord_t y, input coord_t z);
        send(REQ_VERTEX, vi, $urandom, $urandom, x, y, z);
    endtask

    task automatic put_tet(input int ei, input int a, input int b, input int c, input int d);
        send(REQ_CORNER, a, ei, 0, $urandom, $urandom, $urandom);
        send(REQ_CORNER, b, ei, 1, $urandom, $urandom, $urandom);
        send(REQ_CORNER, c, ei, 2, $urandom, $urandom, $urandom);
        send(REQ_CORNER, d, ei, 3, $urandom, $urandom, $urandom);
        built_tets.push_back(ei);
    endtask

    task automatic query(input int ei, input coord_t x, input coord_t y, input coord_t z);
        send(REQ_QUERY, $urandom, ei, $urandom, x, y, z);
    endtask

    function automatic coord_t near_coord(input int span);
        return coord_t'($urandom_range(0, 2 * span) - span);
    endfunction

    initial begin
        int vids[4];
        int ei, nq, span;
        bit paused;
        words_sent = 0;
        paused = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b0;
        @(posedge aclk);
        aresetn <= 1'b1;

        // Unit tetrahedron, full-range tetrahedron and a flat one.
        put_vertex(0, 0, 0, 0);
        put_vertex(1, 1, 0, 0);
        put_vertex(2, 0, 1, 0);
        put_vertex(3, 0, 0, 1);
        put_vertex(4, -32768, -32768, -32768);
        put_vertex(5, 32767, -32768, -32768);
        put_vertex(6, -32768, 32767, -32768);
        put_vertex(7, -32768, -32768, 32767);
        put_vertex(1023, 32767, 32767, 32767);
        put_tet(0, 0, 1, 2, 3);
        put_tet(1023, 4, 5, 6, 7);
        put_tet(1, 0, 0, 1, 1023);
        query(0, 0, 0, 0);
        query(0, 32767, 32767, 32767);
        query(0, -32768, -32768, -32768);
        query(1023, 0, 0, 0);
        query(1023, 32767, 32767, 32767);
        query(1, 5, 5, 5);
        send(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);

        while (words_sent < 450) begin
            no_idle = (words_sent > 180 && words_sent < 260);
            if (!paused && words_sent > 300) begin
                // Let the pipeline drain completely before going on.
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
                paused = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    span = ($urandom_range(0, 3) == 0) ? 32767 : 300;
                    for (int i = 0; i < 4; i++) begin
                        vids[i] = $urandom_range(0, VERTEX_DEPTH - 1);
                        put_vertex(vids[i], near_coord(span), near_coord(span), near_coord(span));
                    end
                    // Now and then a flat tetrahedron with a repeated corner.
                    if ($urandom_range(0, 7) == 0) vids[3] = vids[$urandom_range(0, 2)];
                    ei = $urandom_range(0, ELEMENT_DEPTH - 1);
                    put_tet(ei, vids[0], vids[1], vids[2], vids[3]);
                    nq = $urandom_range(1, 4);
                    for (int i = 0; i < nq; i++)
                        if ($urandom_range(0, 4) == 0)
                            query(ei, $urandom, $urandom, $urandom);
                        else
                            query(ei, near_coord(span), near_coord(span), near_coord(span));
                end
                4, 5, 6, 7: begin
                    ei = built_tets[$urandom_range(0, built_tets.size() - 1)];
                    if ($urandom_range(0, 1) == 0)
                        query(ei, near_coord(300), near_coord(300), near_coord(300));
                    else
                        query(ei, $urandom, $urandom, $urandom);
                end
                8: begin
                    put_vertex($urandom_range(0, VERTEX_DEPTH - 1), $urandom, $urandom, $urandom);
                end
                default: begin
                    send(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                end
            endcase
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tetrahedron_barycentric_weights_top regression: pass");
        end else begin
            $display("tetrahedron_barycentric_weights_top regression: fail");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/tbw_pkg.sv
rtl/tbw_ram.sv
rtl/tbw_fetch.sv
rtl/tbw_det.sv
rtl/tbw_div.sv
rtl/tetrahedron_barycentric_weights_top.sv
test/tbw_checker.sv
test/tb.sv
